// File: src/salru_pkg.sv
`default_nettype none

package salru_pkg;

    localparam int DEF_NUM_SETS    = 128;
    localparam int DEF_NUM_WAYS    = 4;
    localparam int DEF_BLOCK_BYTES = 64;

    localparam int ADDR_W      = 64;
    localparam int WAY_OUT_W   = 2;
    localparam int COUNT_W     = 32;
    localparam int RES_W       = 1 + WAY_OUT_W + 2 * COUNT_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    function automatic int width_min1(input int n);
        int b;
        b = $clog2(n);
        return (b < 1) ? 1 : b;
    endfunction

endpackage

`default_nettype wire

// File: src/salru_set_ram.sv
`default_nettype none

module salru_set_ram #(
    parameter int DEPTH  = 128,
    parameter int IDX_W  = 7,
    parameter int DATA_W = 216
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/salru_way_update.sv
`default_nettype none

// row entry layout, per way from the low end: {used, rank, tag}
module salru_way_update #(
    parameter int NUM_WAYS = 4,
    parameter int TAG_W    = 51,
    parameter int RANK_W   = 2,
    parameter int WAY_W    = 2
) (
    input  wire logic [NUM_WAYS*(TAG_W+RANK_W+1)-1:0] row,
    input  wire logic [TAG_W-1:0]                     req_tag,
    output logic                                      hit,
    output logic      [WAY_W-1:0]                     way,
    output logic      [NUM_WAYS*(TAG_W+RANK_W+1)-1:0] row_new
);

    localparam int ENT_W = TAG_W + RANK_W + 1;
    localparam logic [RANK_W-1:0] RANK_OLD = RANK_W'(NUM_WAYS - 1);

    logic [TAG_W-1:0]  tag_w   [NUM_WAYS];
    logic [RANK_W-1:0] rank_w  [NUM_WAYS];
    logic              used_w  [NUM_WAYS];
    logic [RANK_W-1:0] rank_n  [NUM_WAYS];
    logic              used_n  [NUM_WAYS];
    logic [TAG_W-1:0]  tag_n   [NUM_WAYS];

    logic              found;
    logic              free_found;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  old_way;
    logic [WAY_W-1:0]  chosen;
    logic [RANK_W-1:0] hit_rank;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            tag_w[w]  = row[w*ENT_W +: TAG_W];
            rank_w[w] = row[w*ENT_W + TAG_W +: RANK_W];
            used_w[w] = row[w*ENT_W + TAG_W + RANK_W];
        end
    end

    // descending scans so the lowest matching way wins
    always_comb
    begin
        found      = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        old_way    = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (used_w[w] && (tag_w[w] == req_tag))
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!used_w[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
            if (rank_w[w] == RANK_OLD)
            begin
                old_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        priority if (found)
        begin
            chosen = hit_way;
        end
        else if (free_found)
        begin
            chosen = free_way;
        end
        else
        begin
            chosen = old_way;
        end
    end

    assign hit_rank = rank_w[hit_way];

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            used_n[w] = used_w[w];
            tag_n[w]  = tag_w[w];
            rank_n[w] = rank_w[w];
            if (chosen == WAY_W'(w))
            begin
                rank_n[w] = '0;
                if (!found)
                begin
                    used_n[w] = 1'b1;
                    tag_n[w]  = req_tag;
                end
            end
            else if (found)
            begin
                if (used_w[w] && (rank_w[w] < hit_rank))
                begin
                    rank_n[w] = rank_w[w] + 1'b1;
                end
            end
            else
            begin
                if (used_w[w] && (rank_w[w] < RANK_OLD))
                begin
                    rank_n[w] = rank_w[w] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_new[w*ENT_W +: ENT_W] = {used_n[w], rank_n[w], tag_n[w]};
        end
    end

    assign hit = found;
    assign way = chosen;

endmodule

`default_nettype wire

// File: src/set_assoc_lru_cache_lookup_core.sv
`default_nettype none

// An accepted beat reads its set row, then ST_LOOK compares, writes back and
// registers the result onto m_tvalid. A new beat is taken only after that write
// back through the single set RAM port pair; stalls while the output beat waits.
// Reset: async, clears state and counters, then a pass over all NUM_SETS rows
// clears the set RAM; s_tready stays low until that pass is done.
// NUM_SETS and BLOCK_BYTES are powers of two.
module set_assoc_lru_cache_lookup_core
    import salru_pkg::*;
#(
    parameter int NUM_SETS    = DEF_NUM_SETS,
    parameter int NUM_WAYS    = DEF_NUM_WAYS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [ADDR_W-1:0]      s_tdata,   // address
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata    // hit, way, hit_total, miss_total, zero pad
);

    localparam int OFF_W    = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int SET_W    = width_min1(NUM_SETS);
    localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
    localparam int RANK_W   = width_min1(NUM_WAYS);
    localparam int WAY_W    = width_min1(NUM_WAYS);
    localparam int ROW_W    = NUM_WAYS * (TAG_W + RANK_W + 1);
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [SET_W-1:0]     clr_idx_reg;
    logic [SET_W-1:0]     clr_idx_next;
    logic [SET_W-1:0]     set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [COUNT_W-1:0]   hit_count_reg;
    logic [COUNT_W-1:0]   hit_count_next;
    logic [COUNT_W-1:0]   miss_count_reg;
    logic [COUNT_W-1:0]   miss_count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_hit_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;

    logic                 accept;
    logic                 look_done;
    logic [SET_W-1:0]     in_set;
    logic                 rd_en;
    logic                 wr_en;
    logic [SET_W-1:0]     wr_addr;
    logic [ROW_W-1:0]     wr_data;
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     row_new;
    logic                 upd_hit;
    logic [WAY_W-1:0]     upd_way;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign look_done = (state_reg == ST_LOOK) && (!out_valid_reg || m_tready);
    assign in_set    = (SET_BITS == 0) ? '0 : s_tdata[OFF_W +: SET_W];
    assign rd_en     = accept;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = set_reg;
        wr_data = row_new;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end
        else if (look_done)
        begin
            wr_en = 1'b1;
        end
    end

    salru_set_ram #(
        .DEPTH  (NUM_SETS),
        .IDX_W  (SET_W),
        .DATA_W (ROW_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (in_set),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    salru_way_update #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W),
        .WAY_W    (WAY_W)
    ) u_update (
        .row     (rd_row),
        .req_tag (tag_reg),
        .hit     (upd_hit),
        .way     (upd_way),
        .row_new (row_new)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        hit_count_next  = hit_count_reg;
        miss_count_next = miss_count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (look_done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (upd_hit)
                    begin
                        if (hit_count_reg != '1)
                        begin
                            hit_count_next = hit_count_reg + 1'b1;
                        end
                    end
                    else if (miss_count_reg != '1)
                    begin
                        miss_count_next = miss_count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= in_set;
            tag_reg <= s_tdata[ADDR_W-1 -: TAG_W];
        end
        if (look_done)
        begin
            out_hit_reg <= upd_hit;
            out_way_reg <= WAY_OUT_W'(upd_way);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({miss_count_reg, hit_count_reg, out_way_reg, out_hit_reg});

    // no read and write of the set RAM in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("set RAM read and write overlap");

    a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !look_done |=> ($stable(hit_count_reg) && $stable(miss_count_reg)))
        else $error("counter moved without a lookup");

    a_counters_step: assert property (@(posedge clk) disable iff (!rst_n)
        look_done |=> ((hit_count_reg != $past(hit_count_reg))
                    || (miss_count_reg != $past(miss_count_reg))
                    || ($past(hit_count_reg) == '1)
                    || ($past(miss_count_reg) == '1)))
        else $error("lookup did not count");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOK))
        else $error("accepted beat not looked up");

endmodule

`default_nettype wire
